### src/pixel_point_operation_unit_macros.svh
// assertion macros shared by the pixel point operation unit
`ifndef PIXEL_POINT_OPERATION_UNIT_MACROS_SVH
`define PIXEL_POINT_OPERATION_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is applied
`define PPOU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is applied
`define PPOU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ppou_pkg.sv
// types, codes and per-channel functions of the pixel point operation unit
package ppou_pkg;

	localparam int CHAN_W     = 8;
	localparam int FUNC_W     = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int NUM_CHAN   = 3;
	// odd bytes repeat with period 64 under powers, so six exponent bits matter
	localparam int EXP_LO_W   = 6;

	localparam logic [FUNC_W-1:0] FUNC_SQRT  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_POW   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_LN    = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_LOG2  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_LOG10 = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_MUL   = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 4'd1;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
	} in_req_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] blue_out;
	} out_res_t;

	// per-channel working set carried down the pipeline
	typedef struct packed {
		logic [CHAN_W-1:0] acc;
		logic [CHAN_W-1:0] base;
		logic [CHAN_W-1:0] direct;
		logic              zero;
	} chan_t;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		chan_t [NUM_CHAN-1:0]    chan;
	} stage_t;

	function automatic logic [CHAN_W-1:0] mul8(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		logic [2*CHAN_W-1:0] p;
		p = a * b;
		return p[CHAN_W-1:0];
	endfunction

	function automatic logic [CHAN_W-1:0] isqrt8(input logic [CHAN_W-1:0] c);
		logic [CHAN_W-1:0] r;
		r = '0;
		for (int k = 1; k < 16; k++) begin
			if ({1'b0, c} >= 9'(k * k))
				r = CHAN_W'(k);
		end
		return r;
	endfunction

	function automatic logic [CHAN_W-1:0] ln8(input logic [CHAN_W-1:0] c);
		logic [CHAN_W-1:0] r;
		if (c >= 8'd149)     r = 8'd5;
		else if (c >= 8'd55) r = 8'd4;
		else if (c >= 8'd21) r = 8'd3;
		else if (c >= 8'd8)  r = 8'd2;
		else if (c >= 8'd3)  r = 8'd1;
		else                 r = 8'd0;
		return r;
	endfunction

	function automatic logic [CHAN_W-1:0] log2_8(input logic [CHAN_W-1:0] c);
		logic [CHAN_W-1:0] r;
		r = '0;
		for (int k = 1; k < CHAN_W; k++) begin
			if (c[k])
				r = CHAN_W'(k);
		end
		return r;
	endfunction

	function automatic logic [CHAN_W-1:0] log10_8(input logic [CHAN_W-1:0] c);
		logic [CHAN_W-1:0] r;
		if (c >= 8'd100)     r = 8'd2;
		else if (c >= 8'd10) r = 8'd1;
		else                 r = 8'd0;
		return r;
	endfunction

	// every operation but power, settled in one step
	function automatic logic [CHAN_W-1:0] direct_op(input logic [FUNC_W-1:0] func,
			input logic [CHAN_W-1:0] c, input logic [CHAN_W-1:0] mul);
		logic [CHAN_W-1:0] r;
		case (func)
			FUNC_SQRT:  r = isqrt8(c);
			FUNC_LN:    r = ln8(c);
			FUNC_LOG2:  r = log2_8(c);
			FUNC_LOG10: r = log10_8(c);
			FUNC_MUL:   r = mul8(c, mul);
			default:    r = '0;
		endcase
		return r;
	endfunction

	// one square-and-multiply step of the power chain
	function automatic chan_t pow_step(input chan_t ch, input logic ebit);
		chan_t n;
		n      = ch;
		n.acc  = ebit ? mul8(ch.acc, ch.base) : ch.acc;
		n.base = mul8(ch.base, ch.base);
		return n;
	endfunction

endpackage

### src/pixel_point_operation_unit.sv
// pixel point operation unit: per-channel sqrt, power, logs and multiply on rgb pixels
//
//  channel   signals                               request accepted when
//  -------   -----------------------------------   -------------------------
//  pixel in  start, busy, req                      start && !busy at clk rise
//  pixel out done, res                             done high, one cycle each
//  config    cfg_valid, cfg_ready, cfg_index,      cfg_valid && cfg_ready
//            cfg_data
//
// one pixel request per clock while busy is low; the result passes every stage register and then the output register
// the power operation sets the depth: six square-and-multiply steps, one per stage
// the other operations finish in stage one and ride along to the output
// reset clears the valid bits and loads exponent and multiplier with 1
// busy and cfg_ready hold off requests only while reset is applied and in the first cycle after reset
// the receiver cannot stall, so the pipeline advances every cycle
`include "pixel_point_operation_unit_macros.svh"

module pixel_point_operation_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  ppou_pkg::in_req_t                   req,
	output logic                                done,
	output ppou_pkg::out_res_t                  res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ppou_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ppou_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// configuration, kept only as wide as the arithmetic needs
	logic [ppou_pkg::EXP_LO_W-1:0] exp_lo_q;   // exponent mod 64
	logic                          exp_big_q;  // exponent at least 8
	logic                          exp_zero_q; // exponent exactly 0
	logic [ppou_pkg::CHAN_W-1:0]   mul_q;      // low byte of multiplier
	logic                          busy_q;

	// pipeline valid bits and payload
	logic                 valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	ppou_pkg::stage_t     stage_s1, stage_s2, stage_s3, stage_s4, stage_s5, stage_s6;
	ppou_pkg::stage_t     first_d, step2_d, step3_d, step4_d, step5_d, step6_d;

	logic                 done_q;
	ppou_pkg::out_res_t   res_q;
	ppou_pkg::out_res_t   res_d;

	logic                 accept;
	logic                 cfg_write;
	logic [ppou_pkg::CHAN_W-1:0] chan_in [ppou_pkg::NUM_CHAN];
	logic [ppou_pkg::CHAN_W-1:0] chan_out [ppou_pkg::NUM_CHAN];

	assign busy      = busy_q;
	assign cfg_ready = !busy_q;
	assign accept    = start && !busy_q;
	assign cfg_write = cfg_valid && cfg_ready;

	// busy while reset is applied and in the cycle right after reset release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// config registers; out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_lo_q   <= ppou_pkg::EXP_LO_W'(1);
			exp_big_q  <= 1'b0;
			exp_zero_q <= 1'b0;
			mul_q      <= ppou_pkg::CHAN_W'(1);
		end else if (cfg_write) begin
			case (cfg_index)
				ppou_pkg::CFG_EXPONENT: begin
					exp_lo_q   <= cfg_data[ppou_pkg::EXP_LO_W-1:0];
					exp_big_q  <= |cfg_data[ppou_pkg::CFG_DATA_W-1:3];
					exp_zero_q <= (cfg_data == '0);
				end
				ppou_pkg::CFG_MULTIPLIER: begin
					mul_q <= cfg_data[ppou_pkg::CHAN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign chan_in[0] = req.red_in;
	assign chan_in[1] = req.green_in;
	assign chan_in[2] = req.blue_in;

	// stage one: direct operations, first power step, even-base flag
	// an even base with exponent >= 8 carries 2^8 and so is 0 mod 256
	always_comb begin
		first_d.func = req.func;
		for (int ch = 0; ch < ppou_pkg::NUM_CHAN; ch++) begin
			first_d.chan[ch].direct = ppou_pkg::direct_op(req.func, chan_in[ch], mul_q);
			first_d.chan[ch].acc    = exp_lo_q[0] ? chan_in[ch] : ppou_pkg::CHAN_W'(1);
			first_d.chan[ch].base   = ppou_pkg::mul8(chan_in[ch], chan_in[ch]);
			first_d.chan[ch].zero   = !chan_in[ch][0] && exp_big_q;
		end
	end

	// remaining exponent bits, one per stage
	always_comb begin
		step2_d = stage_s1;
		step3_d = stage_s2;
		step4_d = stage_s3;
		step5_d = stage_s4;
		step6_d = stage_s5;
		for (int ch = 0; ch < ppou_pkg::NUM_CHAN; ch++) begin
			step2_d.chan[ch] = ppou_pkg::pow_step(stage_s1.chan[ch], exp_lo_q[1]);
			step3_d.chan[ch] = ppou_pkg::pow_step(stage_s2.chan[ch], exp_lo_q[2]);
			step4_d.chan[ch] = ppou_pkg::pow_step(stage_s3.chan[ch], exp_lo_q[3]);
			step5_d.chan[ch] = ppou_pkg::pow_step(stage_s4.chan[ch], exp_lo_q[4]);
			step6_d.chan[ch] = ppou_pkg::pow_step(stage_s5.chan[ch], exp_lo_q[5]);
		end
	end

	// output select: power result or the value settled in stage one
	always_comb begin
		for (int ch = 0; ch < ppou_pkg::NUM_CHAN; ch++) begin
			if (stage_s6.func == ppou_pkg::FUNC_POW) begin
				chan_out[ch] = stage_s6.chan[ch].zero ? '0 : stage_s6.chan[ch].acc;
			end else begin
				chan_out[ch] = stage_s6.chan[ch].direct;
			end
		end
		res_d.red_out   = chan_out[0];
		res_d.green_out = chan_out[1];
		res_d.blue_out  = chan_out[2];
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			done_q   <= valid_s6;
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		stage_s1 <= first_d;
		stage_s2 <= step2_d;
		stage_s3 <= step3_d;
		stage_s4 <= step4_d;
		stage_s5 <= step5_d;
		stage_s6 <= step6_d;
		res_q    <= res_d;
	end

	assign done = done_q;
	assign res  = res_q;

	// every accepted request comes out through the stage registers and the output register, and nothing else does
	`PPOU_ASSERT_IMP(a_latency_out, $past(accept, 7), done, "accepted request lost")
	`PPOU_ASSERT_IMP(a_latency_in, done, $past(accept, 7), "result without request")
	// exponent zero makes the power chain give 1 on every channel
	`PPOU_ASSERT_NXT(a_pow_exp_zero,
		valid_s6 && stage_s6.func == ppou_pkg::FUNC_POW && exp_zero_q,
		res.red_out == 8'd1 && res.green_out == 8'd1 && res.blue_out == 8'd1,
		"power with zero exponent is not 1")
	// log2 of a byte never exceeds 7
	`PPOU_ASSERT_NXT(a_log2_range,
		valid_s6 && stage_s6.func == ppou_pkg::FUNC_LOG2,
		res.red_out < 8'd8 && res.green_out < 8'd8 && res.blue_out < 8'd8,
		"log2 result out of range")

endmodule
